// ===== sv/lpi_pkg.sv =====
// ----------------------------------------------------------------------------
// lpi_pkg: shared types and constants for the line/plane intersection block
// Coordinate widths, request and result formats, and the record that moves
// down the divider chain.
// ----------------------------------------------------------------------------
package lpi_pkg;

  // Coordinate width (signed fixed point). The result does not depend on the
  // position of the binary point, so no fraction width is needed here.
  localparam int CW   = 32;
  localparam int DW   = CW + 1;          // b - a and p - a
  localparam int PPW  = CW + DW;         // n * (b - a)
  localparam int SW   = PPW + 2;         // sum of three products
  localparam int MW   = 2 * CW + 1;      // magnitude of num and den
  localparam int PW   = 3 * CW + 1;      // magnitude of (b - a) * num
  localparam int QS   = CW + 1;          // offset magnitude below 2^QS unless overflow
  localparam int QB   = QS + 1;          // quotient bits, one extra for rounding
  localparam int WKW  = MW + QB;         // partial remainder and dividend/quotient bits
  localparam int SUMW = CW + 4;          // start plus rounded offset

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_DEGEN = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  typedef struct packed {
    logic signed [CW-1:0] plane_px;
    logic signed [CW-1:0] plane_py;
    logic signed [CW-1:0] plane_pz;
    logic signed [CW-1:0] normal_x;
    logic signed [CW-1:0] normal_y;
    logic signed [CW-1:0] normal_z;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } item_t;

  typedef struct packed {
    logic signed [CW-1:0] hit_x;
    logic signed [CW-1:0] hit_y;
    logic signed [CW-1:0] hit_z;
    status_t              status;
  } result_t;

  // One request in flight through the divider chain, all three axes.
  typedef struct packed {
    logic [2:0][CW-1:0]  start;
    logic [MW-1:0]       den;
    logic [2:0]          neg;
    logic [2:0]          ovf;
    logic                degen;
    logic [2:0][WKW-1:0] work;
  } div_item_t;

endpackage

// ===== sv/lpi_front.sv =====
// ----------------------------------------------------------------------------
// lpi_front: dot products and dividend preparation
// Seven register stages: differences, products, sums, magnitudes, split
// multiply, partial product sum, and the overflow check with the first
// partial remainder for the divider chain.
// ----------------------------------------------------------------------------
module lpi_front import lpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  item_t     in_item,
  output logic      out_valid,
  output div_item_t out_item
);

  logic signed [CW-1:0] pv [3];
  logic signed [CW-1:0] nv [3];
  logic signed [CW-1:0] av [3];
  logic signed [CW-1:0] bv [3];

  logic [6:1] vld;

  logic signed [CW-1:0]  a1 [3];
  logic signed [CW-1:0]  n1 [3];
  logic signed [DW-1:0]  d1 [3];
  logic signed [DW-1:0]  e1 [3];

  logic signed [CW-1:0]  a2 [3];
  logic signed [DW-1:0]  d2 [3];
  logic signed [PPW-1:0] mn2 [3];
  logic signed [PPW-1:0] md2 [3];

  logic signed [CW-1:0]  a3 [3];
  logic signed [DW-1:0]  d3 [3];
  logic signed [SW-1:0]  num3;
  logic signed [SW-1:0]  den3;

  logic signed [CW-1:0]  a4 [3];
  logic [CW-1:0]         dmag4 [3];
  logic [MW-1:0]         numag4;
  logic [MW-1:0]         den4;
  logic [2:0]            neg4;
  logic                  degen4;

  logic signed [CW-1:0]  a5 [3];
  logic [MW-1:0]         den5;
  logic [2:0]            neg5;
  logic                  degen5;
  logic [2*CW-1:0]       lo5 [3];
  logic [2*CW:0]         hi5 [3];

  logic signed [CW-1:0]  a6 [3];
  logic [MW-1:0]         den6;
  logic [2:0]            neg6;
  logic                  degen6;
  logic [PW-1:0]         prod6 [3];

  logic [SW-1:0]         num_abs;
  logic [SW-1:0]         den_abs;
  logic [DW-1:0]         d_abs [3];
  logic [PW-QS-1:0]      r0 [3];

  always_comb begin
    pv[0] = in_item.plane_px; pv[1] = in_item.plane_py; pv[2] = in_item.plane_pz;
    nv[0] = in_item.normal_x; nv[1] = in_item.normal_y; nv[2] = in_item.normal_z;
    av[0] = in_item.start_x;  av[1] = in_item.start_y;  av[2] = in_item.start_z;
    bv[0] = in_item.end_x;    bv[1] = in_item.end_y;    bv[2] = in_item.end_z;
  end

  always_comb begin
    num_abs = num3[SW-1] ? SW'(-num3) : SW'(num3);
    den_abs = den3[SW-1] ? SW'(-den3) : SW'(den3);
    for (int i = 0; i < 3; i++) begin
      d_abs[i] = d3[i][DW-1] ? DW'(-d3[i]) : DW'(d3[i]);
      r0[i]    = prod6[i][PW-1:QS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[5:1], in_valid};
      out_valid <= vld[6];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a1[i] <= av[i];
        n1[i] <= nv[i];
        d1[i] <= DW'(bv[i]) - DW'(av[i]);
        e1[i] <= DW'(pv[i]) - DW'(av[i]);

        a2[i]  <= a1[i];
        d2[i]  <= d1[i];
        mn2[i] <= PPW'(n1[i]) * PPW'(e1[i]);
        md2[i] <= PPW'(n1[i]) * PPW'(d1[i]);

        a3[i] <= a2[i];
        d3[i] <= d2[i];

        a4[i]    <= a3[i];
        dmag4[i] <= d_abs[i][CW-1:0];
        neg4[i]  <= d3[i][DW-1] ^ num3[SW-1] ^ den3[SW-1];

        a5[i]  <= a4[i];
        lo5[i] <= (2*CW)'(dmag4[i]) * (2*CW)'(numag4[CW-1:0]);
        hi5[i] <= (2*CW+1)'(dmag4[i]) * (2*CW+1)'(numag4[MW-1:CW]);

        a6[i]    <= a5[i];
        prod6[i] <= PW'(lo5[i]) + (PW'(hi5[i]) << CW);

        out_item.start[i] <= a6[i];
        out_item.ovf[i]   <= MW'(r0[i]) >= den6;
        out_item.work[i]  <= {MW'(r0[i]), prod6[i][QS-1:0], 1'b0};
      end
      num3   <= SW'(mn2[0]) + SW'(mn2[1]) + SW'(mn2[2]);
      den3   <= SW'(md2[0]) + SW'(md2[1]) + SW'(md2[2]);

      numag4 <= num_abs[MW-1:0];
      den4   <= den_abs[MW-1:0];
      degen4 <= den3 == '0;

      den5   <= den4;
      neg5   <= neg4;
      degen5 <= degen4;

      den6   <= den5;
      neg6   <= neg5;
      degen6 <= degen5;

      out_item.den   <= den6;
      out_item.neg   <= neg6;
      out_item.degen <= degen6;
    end
  end

endmodule

// ===== sv/lpi_div_cell.sv =====
// ----------------------------------------------------------------------------
// lpi_div_cell: one restoring division step for all three axes
// Shifts the next dividend bit into the partial remainder, subtracts the
// denominator when it fits, and shifts the quotient bit in at the bottom.
// ----------------------------------------------------------------------------
module lpi_div_cell import lpi_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      en,
  input  logic      in_valid,
  input  div_item_t in_item,
  output logic      out_valid,
  output div_item_t out_item
);

  div_item_t step;

  always_comb begin
    logic [MW:0] trial;
    step = in_item;
    for (int i = 0; i < 3; i++) begin
      trial = in_item.work[i][WKW-1:QB-1];
      if (trial >= {1'b0, in_item.den}) begin
        step.work[i] = {MW'(trial - {1'b0, in_item.den}), in_item.work[i][QB-2:0], 1'b1};
      end else begin
        step.work[i] = {trial[MW-1:0], in_item.work[i][QB-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= step;
    end
  end

endmodule

// ===== sv/lpi_back.sv =====
// ----------------------------------------------------------------------------
// lpi_back: rounding, final add and saturation
// Turns the doubled quotient into a rounded offset, adds it to the line
// start and clamps each axis to the coordinate range.
// ----------------------------------------------------------------------------
module lpi_back import lpi_pkg::*; (
  input  div_item_t in_item,
  output result_t   result
);

  localparam logic signed [SUMW-1:0] MAXV = SUMW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [SUMW-1:0] MINV = -MAXV - SUMW'(1);

  logic signed [CW-1:0] hit [3];
  logic [2:0]           sat;

  always_comb begin
    logic [QB:0]             rnd;
    logic signed [CW+2:0]    offs;
    logic signed [SUMW-1:0]  sum;
    for (int i = 0; i < 3; i++) begin
      // The quotient carries one extra bit; adding one and dropping it rounds
      // half away from zero on the magnitude.
      rnd  = ((QB+1)'(in_item.work[i][QB-1:0]) + (QB+1)'(1)) >> 1;
      offs = in_item.neg[i] ? -(CW+3)'(rnd) : (CW+3)'(rnd);
      sum  = SUMW'($signed(in_item.start[i])) + SUMW'(offs);
      sat[i] = 1'b0;
      if (in_item.ovf[i]) begin
        sat[i] = 1'b1;
        hit[i] = in_item.neg[i] ? MINV[CW-1:0] : MAXV[CW-1:0];
      end else if (sum > MAXV) begin
        sat[i] = 1'b1;
        hit[i] = MAXV[CW-1:0];
      end else if (sum < MINV) begin
        sat[i] = 1'b1;
        hit[i] = MINV[CW-1:0];
      end else begin
        hit[i] = sum[CW-1:0];
      end
    end
  end

  always_comb begin
    if (in_item.degen) begin
      result.hit_x  = in_item.start[0];
      result.hit_y  = in_item.start[1];
      result.hit_z  = in_item.start[2];
      result.status = STATUS_DEGEN;
    end else begin
      result.hit_x  = hit[0];
      result.hit_y  = hit[1];
      result.hit_z  = hit[2];
      result.status = (sat != 3'b000) ? STATUS_SAT : STATUS_OK;
    end
  end

endmodule

// ===== sv/line_plane_intersection.sv =====
// ----------------------------------------------------------------------------
// line_plane_intersection: line segment against plane, signed fixed point
// Each request holds a plane point, a plane normal of any length and a line
// start and end point. The result is start + (end - start) * t with
// t = n.(p - start) / n.(end - start), each axis rounded to the nearest LSB.
//
// Channels: item/item_valid/item_ready in, result/result_valid/result_ready
// out, both valid/ready. One request is accepted every cycle while the
// output side keeps up. From acceptance to result_valid a request passes
// 7 stages of products and sums, a row of 34 division cells (one quotient
// bit per cell, three axes side by side), and the output register.
// A zero denominator returns the start point with status DEGEN; an axis
// outside the coordinate range is clamped and status reads SAT.
// When the receiver stalls, one more result lands in a skid register and the
// whole pipeline then holds; item_ready drops until the skid drains.
// Synchronous reset empties the pipeline and the output; item_ready is low
// while rst is high.
// ----------------------------------------------------------------------------
module line_plane_intersection import lpi_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic      en;
  logic      skid_valid;
  result_t   skid;
  result_t   tail_result;

  logic      chain_valid [QB+1];
  div_item_t chain_item  [QB+1];

  assign en         = !skid_valid;
  assign item_ready = !skid_valid && !rst;

  lpi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (item_valid && item_ready),
    .in_item   (item),
    .out_valid (chain_valid[0]),
    .out_item  (chain_item[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_cell
    lpi_div_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .in_valid  (chain_valid[g]),
      .in_item   (chain_item[g]),
      .out_valid (chain_valid[g+1]),
      .out_item  (chain_item[g+1])
    );
  end

  lpi_back u_back (
    .in_item (chain_item[QB]),
    .result  (tail_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      skid_valid   <= 1'b0;
    end else if (!skid_valid) begin
      if (chain_valid[QB]) begin
        if (!result_valid || result_ready) begin
          result_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end else if (result_ready) begin
      skid_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (chain_valid[QB]) begin
        if (!result_valid || result_ready) begin
          result <= tail_result;
        end else begin
          skid <= tail_result;
        end
      end
    end else if (result_ready) begin
      result <= skid;
    end
  end

endmodule

// ===== sv/lpi_checker.sv =====
// ----------------------------------------------------------------------------
// lpi_checker: port-level checks for the line/plane intersection block
// Watches the request and result channels and the status coding.
// ----------------------------------------------------------------------------
module lpi_checker import lpi_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_ready,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  localparam logic signed [CW-1:0] MAXC = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINC = {1'b1, {(CW-1){1'b0}}};

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result_valid high after reset");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  // Requests are refused only while a result has been waiting on the receiver.
  a_ready_backpressure: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> result_valid && !$past(result_ready))
    else $error("item_ready low without a stalled result");

  // A saturated result has at least one axis at a range bound.
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == STATUS_SAT |->
      result.hit_x == MAXC || result.hit_x == MINC ||
      result.hit_y == MAXC || result.hit_y == MINC ||
      result.hit_z == MAXC || result.hit_z == MINC)
    else $error("saturated status without a clamped axis");

endmodule

bind line_plane_intersection lpi_checker u_checker (.*);
